FILE: rtl/cdcb_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the content-defined chunk boundary unit.
package cdcb_pkg;

  localparam int MIN_GAP_BYTES = 64;
  localparam int HIST_DEPTH    = 64;
  localparam int HASH_W        = 3;

  localparam int TIER0_LEN  = 4;
  localparam int TIER1_LEN  = 16;
  localparam int TIER2_LEN  = HIST_DEPTH;
  localparam int TIER0_BITS = 3;
  localparam int TIER1_BITS = 2;
  localparam int TIER2_BITS = 2;

  localparam int GAP_W   = $clog2(MIN_GAP_BYTES + 3);
  localparam int GAP_SAT = MIN_GAP_BYTES + 1;

  localparam int OFFSET_W = 32;
  localparam int SEED_W   = 32;
  localparam int BYTE_W   = 8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic first;
    logic tier_pass;
  } req_t;

endpackage

FILE: rtl/cdcb_front.sv
`timescale 1ns / 1ps
// Front end: takes bytes, keeps the mod-8 rolling tier sums, classifies each request.
module cdcb_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [cdcb_pkg::SEED_W-1:0]      cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [cdcb_pkg::BYTE_W-1:0]      data_byte,
  input  logic                             first_of_file,
  output logic                             q_valid,
  input  logic                             q_stall,
  output cdcb_pkg::req_t                   q_data
);

  logic [cdcb_pkg::HASH_W-1:0] seed;
  logic [cdcb_pkg::HASH_W-1:0] hist [cdcb_pkg::HIST_DEPTH];
  logic [cdcb_pkg::HASH_W-1:0] sum0;
  logic [cdcb_pkg::HASH_W-1:0] sum1;
  logic [cdcb_pkg::HASH_W-1:0] sum2;
  logic [cdcb_pkg::HASH_W-1:0] sum0_next;
  logic [cdcb_pkg::HASH_W-1:0] sum1_next;
  logic [cdcb_pkg::HASH_W-1:0] sum2_next;
  logic [cdcb_pkg::HASH_W-1:0] low_bits;
  logic [cdcb_pkg::HASH_W-1:0] h0;
  logic [cdcb_pkg::HASH_W-1:0] h1;
  logic [cdcb_pkg::HASH_W-1:0] h2;
  logic                        take;

  // x31 == -1 mod 8: hash over an even-length window is seed plus an alternating sum
  assign low_bits = data_byte[cdcb_pkg::HASH_W-1:0];
  assign h0 = seed + sum0;
  assign h1 = seed + sum1;
  assign h2 = seed + sum2;

  assign sum0_next = hist[cdcb_pkg::TIER0_LEN-1] - low_bits - sum0;
  assign sum1_next = hist[cdcb_pkg::TIER1_LEN-1] - low_bits - sum1;
  assign sum2_next = hist[cdcb_pkg::TIER2_LEN-1] - low_bits - sum2;

  assign take     = in_valid && !q_stall;
  assign in_stall = q_stall;
  assign q_valid  = in_valid;

  always_comb begin
    q_data.first     = first_of_file;
    q_data.tier_pass = (h0[cdcb_pkg::TIER0_BITS-1:0] == '0) &&
                       (h1[cdcb_pkg::TIER1_BITS-1:0] == '0) &&
                       (h2[cdcb_pkg::TIER2_BITS-1:0] == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cfg_write) begin
      seed <= cfg_data[cdcb_pkg::HASH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum0 <= '0;
      sum1 <= '0;
      sum2 <= '0;
      for (int i = 0; i < cdcb_pkg::HIST_DEPTH; i++) begin
        hist[i] <= '0;
      end
    end else if (take) begin
      sum0    <= sum0_next;
      sum1    <= sum1_next;
      sum2    <= sum2_next;
      hist[0] <= low_bits;
      for (int i = 1; i < cdcb_pkg::HIST_DEPTH; i++) begin
        hist[i] <= hist[i-1];
      end
    end
  end

endmodule

FILE: rtl/cdcb_queue.sv
`timescale 1ns / 1ps
// Short request queue between the front end and the back end.
module cdcb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_stall,
  input  cdcb_pkg::req_t push_data,
  output logic           pop_valid,
  input  logic           pop_stall,
  output cdcb_pkg::req_t pop_data
);

  cdcb_pkg::req_t                entries [cdcb_pkg::QUEUE_DEPTH];
  logic [cdcb_pkg::QPTR_W-1:0]   wr_ptr;
  logic [cdcb_pkg::QPTR_W-1:0]   rd_ptr;
  logic [cdcb_pkg::QCNT_W-1:0]   count;
  logic                          push;
  logic                          pop;

  assign push_stall = (count == cdcb_pkg::QCNT_W'(cdcb_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == cdcb_pkg::QPTR_W'(cdcb_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == cdcb_pkg::QPTR_W'(cdcb_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cdcb_pkg::QCNT_W'(cdcb_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count missed a push");

endmodule

FILE: rtl/cdcb_back.sv
`timescale 1ns / 1ps
// Back end: offset and gap bookkeeping, boundary decision, output register.
module cdcb_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  output logic                             q_stall,
  input  cdcb_pkg::req_t                   q_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             starts_blob,
  output logic [cdcb_pkg::OFFSET_W-1:0]    byte_offset
);

  logic [cdcb_pkg::OFFSET_W-1:0] pos;
  logic [cdcb_pkg::GAP_W-1:0]    gap;
  logic [cdcb_pkg::OFFSET_W-1:0] offset;
  logic [cdcb_pkg::GAP_W-1:0]    span;
  logic [cdcb_pkg::GAP_W-1:0]    span_inc;
  logic [cdcb_pkg::GAP_W-1:0]    gap_next;
  logic                          start;
  logic                          take;

  assign take    = q_valid && (!out_valid || !out_stall);
  assign q_stall = out_valid && out_stall;

  assign offset   = q_data.first ? '0 : pos;
  assign span     = q_data.first ? '0 : gap;
  assign start    = q_data.first ||
                    ((span > cdcb_pkg::GAP_W'(cdcb_pkg::MIN_GAP_BYTES)) && q_data.tier_pass);
  assign span_inc = span + 1'b1;
  assign gap_next = start ? cdcb_pkg::GAP_W'(1) :
                    (span_inc > cdcb_pkg::GAP_W'(cdcb_pkg::GAP_SAT)) ?
                    cdcb_pkg::GAP_W'(cdcb_pkg::GAP_SAT) : span_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      gap       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        pos       <= offset + 1'b1;
        gap       <= gap_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      starts_blob <= start;
      byte_offset <= offset;
    end
  end

  a_gap_sat: assert property (@(posedge clk) disable iff (rst)
    gap <= cdcb_pkg::GAP_W'(cdcb_pkg::GAP_SAT))
    else $error("gap counter above saturation");

  a_first_starts: assert property (@(posedge clk) disable iff (rst)
    (take && q_data.first) |=> (out_valid && starts_blob && byte_offset == '0))
    else $error("first byte of file did not start a chunk at offset zero");

  a_start_resets_gap: assert property (@(posedge clk) disable iff (rst)
    (take && start) |=> (gap == cdcb_pkg::GAP_W'(1)))
    else $error("gap not restarted after chunk start");

endmodule

FILE: rtl/content_defined_chunk_boundary_unit.sv
`timescale 1ns / 1ps
// Top level of the content-defined chunk boundary unit.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------
//   in      | input     | in_valid / in_stall  | data_byte, first_of_file
//   out     | output    | out_valid/ out_stall | starts_blob, byte_offset
//   cfg     | input     | cfg_write            | cfg_data (path seed)
//
// One byte per cycle sustained while out_stall is low, through the mod-8 window sum
// update in the front end and the gap/offset update in the back end.
// An accepted request is held in the queue, then in the back end output register.
// rst is synchronous: clears history, tier sums, seed, counters and the queue.
// out_stall holds the output register, then fills the two-entry queue; in_stall
// rises when the queue is full.
module content_defined_chunk_boundary_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [cdcb_pkg::SEED_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cdcb_pkg::BYTE_W-1:0]   data_byte,
  input  logic                          first_of_file,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          starts_blob,
  output logic [cdcb_pkg::OFFSET_W-1:0] byte_offset
);

  logic           fq_valid;
  logic           fq_stall;
  cdcb_pkg::req_t fq_data;
  logic           qb_valid;
  logic           qb_stall;
  cdcb_pkg::req_t qb_data;

  cdcb_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .first_of_file (first_of_file),
    .q_valid       (fq_valid),
    .q_stall       (fq_stall),
    .q_data        (fq_data)
  );

  cdcb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_stall (fq_stall),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_stall  (qb_stall),
    .pop_data   (qb_data)
  );

  cdcb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (qb_valid),
    .q_stall     (qb_stall),
    .q_data      (qb_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .starts_blob (starts_blob),
    .byte_offset (byte_offset)
  );

endmodule
